// ===== design/mwdg_pkg.sv =====
`timescale 1ns / 1ps

package mwdg_pkg;

  // Timebase and dwell arithmetic
  localparam int unsigned TICK_HZ   = 1000000;
  localparam int unsigned DWELL_W   = $clog2(TICK_HZ + 1);
  localparam int unsigned CNT_W     = $clog2(DWELL_W);
  localparam int unsigned STEPS_W   = 9;
  localparam int unsigned DIVISOR_W = 8 + STEPS_W;

  // Output scaling, full scale of 12 V split as 3 * 2^2 (linear) and 3 * 2^17 (sine)
  localparam int unsigned FULL_SCALE_VOLTS = 12;
  localparam int unsigned HALF_SCALE       = FULL_SCALE_VOLTS / 2;
  localparam int unsigned SINE_POINTS      = 91;
  localparam int unsigned SINE_ONE         = 32768;
  localparam int unsigned SINE_BASE        = HALF_SCALE * SINE_ONE;
  localparam int unsigned NUM_W            = $clog2(2 * SINE_BASE + 1);
  localparam int unsigned SCALED_W         = NUM_W + 8;
  localparam int unsigned SINE_SHIFT       = 17;
  localparam int unsigned LIN_SHIFT        = 2;
  localparam int unsigned V_W              = 10;
  // floor(v / 3) == (v * 683) >> 11 for every v below 2048
  localparam int unsigned RECIP_3          = 683;
  localparam int unsigned RECIP_SH         = 11;
  localparam int unsigned RECIP_W          = V_W + RECIP_SH;

  // Step counts per shape
  localparam logic [STEPS_W-1:0] STEPS_SQUARE = 9'd2;
  localparam logic [STEPS_W-1:0] STEPS_STAIR  = 9'd5;
  localparam logic [STEPS_W-1:0] STEPS_SINE   = 9'd360;
  localparam logic [STEPS_W-1:0] STEPS_TRI    = 9'd510;
  localparam logic [STEPS_W-1:0] QUARTER      = 9'd90;

  // Waveform codes
  localparam logic [2:0] MODE_HOLD   = 3'd0;
  localparam logic [2:0] MODE_SQUARE = 3'd1;
  localparam logic [2:0] MODE_STAIR  = 3'd2;
  localparam logic [2:0] MODE_SINE   = 3'd3;
  localparam logic [2:0] MODE_TRI    = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_WAVE_MODE = 2'd0;
  localparam logic [1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [1:0] REG_FREQ_HZ   = 2'd2;

  // Quarter sine, Q1.15
  localparam logic [15:0] SINE_Q15 [SINE_POINTS] = '{
    16'd0,     16'd573,   16'd1144,  16'd1714,  16'd2287,  16'd2857,  16'd3424,
    16'd3994,  16'd4561,  16'd5125,  16'd5689,  16'd6252,  16'd6812,  16'd7370,
    16'd7927,  16'd8480,  16'd9031,  16'd9581,  16'd10125, 16'd10669, 16'd11207,
    16'd11744, 16'd12275, 16'd12802, 16'd13327, 16'd13848, 16'd14365, 16'd14877,
    16'd15385, 16'd15886, 16'd16384, 16'd16876, 16'd17364, 16'd17845, 16'd18324,
    16'd18796, 16'd19261, 16'd19720, 16'd20175, 16'd20621, 16'd21063, 16'd21499,
    16'd21925, 16'd22348, 16'd22764, 16'd23170, 16'd23570, 16'd23967, 16'd24350,
    16'd24730, 16'd25100, 16'd25464, 16'd25821, 16'd26169, 16'd26509, 16'd26844,
    16'd27165, 16'd27483, 16'd27787, 16'd28089, 16'd28377, 16'd28659, 16'd28931,
    16'd29196, 16'd29452, 16'd29698, 16'd29934, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30982, 16'd31166, 16'd31336, 16'd31500, 16'd31651, 16'd31795,
    16'd31929, 16'd32050, 16'd32165, 16'd32270, 16'd32365, 16'd32450, 16'd32522,
    16'd32588, 16'd32643, 16'd32689, 16'd32722, 16'd32748, 16'd32761, 16'd32768
  };

  // Commands from the controller
  typedef struct packed {
    logic accept;     // input word taken
    logic cfg_write;  // config word taken
    logic div_load;   // start dwell division
    logic div_step;   // one quotient bit
    logic mul_en;     // product stage
    logic scale_en;   // scale stage
    logic code_en;    // divide-by-three and update held code
    logic push;       // load output register
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic calc;       // current input word advances the waveform
    logic cfg_hit;    // config index names a register
    logic div_last;   // last quotient bit this cycle
    logic out_free;   // output register can take a word
  } status_t;

  function automatic logic [STEPS_W-1:0] steps_of(input logic [2:0] mode);
    logic [STEPS_W-1:0] s;
    case (mode)
      MODE_SQUARE: s = STEPS_SQUARE;
      MODE_STAIR:  s = STEPS_STAIR;
      MODE_SINE:   s = STEPS_SINE;
      MODE_TRI:    s = STEPS_TRI;
      default:     s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/multi_waveform_dac_generator.sv =====
`timescale 1ns / 1ps
// Input word with a tick while running: the word passes the product, scale, divide-by-three and push states.
// Input word without a tick, or while no waveform runs: the word goes straight to the push state. The push waits
// for a free output register, and no new word is accepted until it is done. A register write runs the dwell
// division, one quotient bit a cycle, through the divisor load and divide states, with no input accepted meanwhile.
// Reset (rst_ni low, asynchronous): registers zero, hold mode, code 0, dwell length 1.

module multi_waveform_dac_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] dac_code, [8] period_start, [9] running, [15:10] zero
);
  import mwdg_pkg::*;

  cmd_t    cmd;
  status_t status;

  mwdg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  mwdg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // input and config words never taken together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tvalid && s_axis_tready && cfg_valid_i && cfg_ready_o))
    else $error("input and config accepted in the same cycle");

  // a register write starts the division, so no input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o &&
     (cfg_index_i == REG_WAVE_MODE || cfg_index_i == REG_AMPLITUDE ||
      cfg_index_i == REG_FREQ_HZ)) |=> !s_axis_tready)
    else $error("input ready during dwell division");

  // one word in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready while a word is in flight");

  // period start only while a waveform runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[9]) |-> !m_axis_tdata[8])
    else $error("period start flagged in hold");
`endif

endmodule

// ===== design/mwdg_ctrl.sv =====
`timescale 1ns / 1ps

module mwdg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  mwdg_pkg::status_t status_i,
  output mwdg_pkg::cmd_t    cmd_o
);
  import mwdg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIVIDE,
    ST_MUL,
    ST_SCALE,
    ST_DIV3,
    ST_PUSH
  } state_e;

  state_e state_q;
  logic   idle;

  assign idle          = (state_q == ST_IDLE);
  assign cfg_ready_o   = idle;
  assign s_axis_tready = idle & ~cfg_valid_i;

  // Command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.cfg_write = idle & cfg_valid_i;
    cmd_o.accept    = idle & ~cfg_valid_i & s_axis_tvalid;
    cmd_o.div_load  = (state_q == ST_PROD);
    cmd_o.div_step  = (state_q == ST_DIVIDE);
    cmd_o.mul_en    = (state_q == ST_MUL);
    cmd_o.scale_en  = (state_q == ST_SCALE);
    cmd_o.code_en   = (state_q == ST_DIV3);
    cmd_o.push      = (state_q == ST_PUSH) & status_i.out_free;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.cfg_write) begin
            if (status_i.cfg_hit) state_q <= ST_PROD;
          end else if (cmd_o.accept) begin
            state_q <= status_i.calc ? ST_MUL : ST_PUSH;
          end
        end
        ST_PROD:   state_q <= ST_DIVIDE;
        ST_DIVIDE: begin
          if (status_i.div_last) state_q <= ST_IDLE;
        end
        ST_MUL:    state_q <= ST_SCALE;
        ST_SCALE:  state_q <= ST_DIV3;
        ST_DIV3:   state_q <= ST_PUSH;
        ST_PUSH: begin
          if (status_i.out_free) state_q <= ST_IDLE;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/mwdg_datapath.sv =====
`timescale 1ns / 1ps

module mwdg_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mwdg_pkg::cmd_t    cmd_i,
  output mwdg_pkg::status_t status_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [7:0]        s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata
);
  import mwdg_pkg::*;

  // Configuration registers
  logic [2:0] mode_q;
  logic [7:0] amp_q;
  logic [7:0] freq_q;

  // Step state
  logic [STEPS_W-1:0] step_q;
  logic [DWELL_W-1:0] dc_q;
  logic [DWELL_W-1:0] len_q;
  logic [7:0]         held_q;

  // Per-word pipeline
  logic [STEPS_W-1:0] p_q;
  logic               start_q;
  logic               run_q;
  logic               neg_q;
  logic [NUM_W-1:0]   prod_q;
  logic [V_W-1:0]     v_q;

  // Divider
  logic [DIVISOR_W-1:0] divisor_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DWELL_W-1:0]   num_q;
  logic [DWELL_W-1:0]   quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 div_run_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_code_q;
  logic       out_start_q;
  logic       out_run_q;

  logic [STEPS_W-1:0] steps;
  logic               run;
  logic               wrap;
  logic [STEPS_W-1:0] p_eff;
  logic [STEPS_W-1:0] p_inc;
  logic [DWELL_W-1:0] dc_eff;
  logic [DWELL_W-1:0] dc_inc;

  assign steps  = steps_of(mode_q);
  assign run    = (steps != '0) && (freq_q != 8'd0);
  assign wrap   = (step_q >= steps);
  assign p_eff  = wrap ? '0 : step_q;
  assign dc_eff = wrap ? '0 : dc_q;
  assign p_inc  = p_eff + 9'd1;
  assign dc_inc = dc_eff + DWELL_W'(1);

  assign status_o.calc     = run & s_axis_tdata[0];
  assign status_o.cfg_hit  = (cfg_index_i == REG_WAVE_MODE) ||
                             (cfg_index_i == REG_AMPLITUDE) ||
                             (cfg_index_i == REG_FREQ_HZ);
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.out_free = ~out_valid_q | m_axis_tready;

  // Config registers and step state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HOLD;
      amp_q  <= '0;
      freq_q <= '0;
      step_q <= '0;
      dc_q   <= '0;
    end else if (cmd_i.cfg_write) begin
      case (cfg_index_i)
        REG_WAVE_MODE: mode_q <= cfg_data_i[2:0];
        REG_AMPLITUDE: amp_q  <= cfg_data_i;
        REG_FREQ_HZ:   freq_q <= cfg_data_i;
        default:       ;
      endcase
      if (status_o.cfg_hit) begin
        step_q <= '0;
        dc_q   <= '0;
      end
    end else if (cmd_i.accept && status_o.calc) begin
      if (dc_inc >= len_q) begin
        dc_q   <= '0;
        step_q <= (p_inc >= steps) ? '0 : p_inc;
      end else begin
        dc_q   <= dc_inc;
        step_q <= p_eff;
      end
    end
  end

  // Word attributes captured on accept
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      p_q     <= p_eff;
      start_q <= status_o.calc && (p_eff == '0) && (dc_eff == '0);
      run_q   <= run;
    end
  end

  // Dwell division, one quotient bit a cycle
  logic [DIVISOR_W:0]   rem_sh;
  logic                 ge;
  logic [DIVISOR_W:0]   rem_nx;
  logic [DWELL_W-1:0]   quo_nx;

  assign rem_sh = {rem_q, num_q[DWELL_W-1]};
  assign ge     = (rem_sh >= {1'b0, divisor_q});
  assign rem_nx = ge ? (rem_sh - {1'b0, divisor_q}) : rem_sh;
  assign quo_nx = {quo_q[DWELL_W-2:0], ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      divisor_q <= {{(DIVISOR_W-8){1'b0}}, freq_q} *
                   {{(DIVISOR_W-STEPS_W){1'b0}}, steps};
      div_run_q <= run;
      rem_q     <= '0;
      num_q     <= DWELL_W'(TICK_HZ);
      quo_q     <= '0;
      cnt_q     <= CNT_W'(DWELL_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nx[DIVISOR_W-1:0];
      num_q <= {num_q[DWELL_W-2:0], 1'b0};
      quo_q <= quo_nx;
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= DWELL_W'(1);
    end else if (cmd_i.div_step && status_o.div_last) begin
      len_q <= (div_run_q && (quo_nx != '0)) ? quo_nx : DWELL_W'(1);
    end
  end

  // Product stage: amplitude times shape value
  logic [1:0]           quad;
  logic [STEPS_W-1:0]   r_full;
  logic [6:0]           sidx;
  logic [15:0]          sval;
  logic [2:0]           a_sine;
  logic [3:0]           a_lin;
  logic [7:0]           m_lin;
  logic [NUM_W-1:0]     prod_sine;
  logic [NUM_W-1:0]     prod_lin;
  logic [STEPS_W-1:0]   tri_down;

  always_comb begin
    if (p_q >= STEPS_W'(3 * QUARTER))      quad = 2'd3;
    else if (p_q >= STEPS_W'(2 * QUARTER)) quad = 2'd2;
    else if (p_q >= QUARTER)               quad = 2'd1;
    else                                   quad = 2'd0;
  end

  assign r_full   = p_q - ({{(STEPS_W-2){1'b0}}, quad} * QUARTER);
  assign sidx     = quad[0] ? (7'(QUARTER) - r_full[6:0]) : r_full[6:0];
  assign sval     = SINE_Q15[sidx];
  assign a_sine   = (amp_q > 8'(HALF_SCALE)) ? 3'(HALF_SCALE) : amp_q[2:0];
  assign a_lin    = (amp_q > 8'(FULL_SCALE_VOLTS)) ? 4'(FULL_SCALE_VOLTS) : amp_q[3:0];
  assign tri_down = STEPS_TRI - p_q;

  always_comb begin
    case (mode_q)
      MODE_SQUARE: m_lin = (p_q == '0) ? 8'd255 : 8'd0;
      MODE_STAIR:  m_lin = 8'(({5'd0, p_q[2:0]} + 8'd1) * 8'd51);
      MODE_TRI:    m_lin = (p_q < 9'd255) ? p_q[7:0] : tri_down[7:0];
      default:     m_lin = 8'd0;
    endcase
  end

  assign prod_sine = {{(NUM_W-3){1'b0}}, a_sine} * {{(NUM_W-16){1'b0}}, sval};
  assign prod_lin  = {{(NUM_W-4){1'b0}}, a_lin} * {{(NUM_W-8){1'b0}}, m_lin};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= (mode_q == MODE_SINE) ? prod_sine : prod_lin;
      neg_q  <= quad[1];
    end
  end

  // Scale stage: for sine, offset, times 255, drop the power-of-two part of full scale; linear shapes only drop it
  logic [NUM_W-1:0]    base;
  logic [NUM_W-1:0]    num;
  logic [SCALED_W-1:0] scaled;

  assign base   = NUM_W'(SINE_BASE);
  assign num    = neg_q ? ((base >= prod_q) ? (base - prod_q) : '0) : (base + prod_q);
  assign scaled = {num, 8'd0} - {8'd0, num};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      v_q <= (mode_q == MODE_SINE) ? scaled[SINE_SHIFT +: V_W] : prod_q[LIN_SHIFT +: V_W];
    end
  end

  // Divide by three through the reciprocal, saturate to eight bits
  logic [RECIP_W-1:0] recip_prod;
  logic [V_W-1:0]     code_w;

  assign recip_prod = {{RECIP_SH{1'b0}}, v_q} * RECIP_W'(RECIP_3);
  assign code_w     = recip_prod[RECIP_SH +: V_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (cmd_i.code_en) begin
      held_q <= (code_w > 10'd255) ? 8'hff : code_w[7:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_code_q  <= held_q;
      out_start_q <= start_q;
      out_run_q   <= run_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_run_q, out_start_q, out_code_q};

endmodule
